// File: rtl/core/hlt_pkg.sv
// Shared constants, types and helpers for the Haar line transform.
// Used by the scale unit, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package hlt_pkg;

	localparam int MAX_LINE   = 64;
	localparam int HALF_MAX   = MAX_LINE / 2;
	localparam int LEN_W      = 7;
	localparam int POS_W      = $clog2(MAX_LINE);
	localparam int IDX_W      = $clog2(HALF_MAX);
	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;

	// 1/sqrt2 in Q0.16
	localparam int COEF_W = 16;
	localparam logic [COEF_W-1:0] INV_SQRT2_Q16 = 16'd46341;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd1;

	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_INVERSE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDLOW,
		ST_ISSUE,
		ST_WAIT,
		ST_PUSH,
		ST_DRAIN_RD,
		ST_DRAIN_PUSH
	} hlt_state_t;

	// request to the shared scale unit
	typedef struct packed {
		logic go;
		logic sub;
	} hlt_op_t;

	// even length, clamped to 2..MAX_LINE
	function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len_cfg);
		logic [LEN_W-1:0] len;
		len = {len_cfg[LEN_W-1:1], 1'b0};
		if (len < LEN_W'(2))
			len = LEN_W'(2);
		if (len > LEN_W'(MAX_LINE))
			len = LEN_W'(MAX_LINE);
		return len;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/haar_line_transform.sv
// One-level Haar line transform, forward or inverse; output stalls hold the work.
// Forward: an even sample is held; an odd sample gives the low out after two scale
// passes and a load; line end drains L/2 stored differences.
// Inverse: a first-half sample is stored; a second-half sample gives even out after the
// low read, a scale pass and a load, and odd out after a second pass and load.
// Reset (async, active low): length 64, forward, line position 0.
`timescale 1ns / 1ps
`default_nettype none

module haar_line_transform
	import hlt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] sample,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      coefficient,
	output logic                          last_of_line
);

	hlt_state_t        state_q, state_d;
	logic [LEN_W-1:0]  line_length_q;
	logic              direction_q;
	logic [POS_W-1:0]  pos_q;
	logic              step_q;
	logic [IDX_W-1:0]  didx_q;
	logic [DATA_W-1:0] held_q, s_q, res_q;
	logic              out_valid_q, last_q;
	logic [DATA_W-1:0] coef_q;

	logic [LEN_W-1:0]  len;
	logic [POS_W-1:0]  half;
	logic [POS_W-1:0]  low_idx;
	logic              is_last, inv_first, drain_last;
	logic              accept, out_free, cfg_hit, fwd;

	hlt_op_t           op;
	logic [DATA_W-1:0] unit_result;
	logic              unit_done;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic              load_out, load_last;
	logic [DATA_W-1:0] load_data;

	assign len        = eff_length(line_length_q);
	assign half       = len[LEN_W-1:1];
	assign low_idx    = pos_q - half;
	assign is_last    = ({1'b0, pos_q} == (len - LEN_W'(1)));
	assign inv_first  = (pos_q < half);
	assign drain_last = ({1'b0, didx_q} == (half - POS_W'(1)));
	assign fwd        = (direction_q == DIR_FORWARD);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cfg_hit = 1'b0;
		if (cfg_write) begin
			unique case (cfg_index)
				CFG_LINE_LENGTH: cfg_hit = 1'b1;
				CFG_DIRECTION:   cfg_hit = 1'b1;
				default:         cfg_hit = 1'b0;
			endcase
		end
	end

	hlt_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (held_q),
		.b      (s_q),
		.result (unit_result),
		.done   (unit_done)
	);

	hlt_ram #(
		.WIDTH (DATA_W),
		.DEPTH (HALF_MAX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (fwd && pos_q[0])
						state_d = ST_ISSUE;
					else if (!fwd && !inv_first)
						state_d = ST_RDLOW;
				end
			end
			ST_RDLOW: state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (unit_done)
					state_d = (fwd && !step_q) ? ST_ISSUE : ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) begin
					if (!step_q)
						state_d = ST_ISSUE;
					else if (is_last && fwd)
						state_d = ST_DRAIN_RD;
					else
						state_d = ST_IDLE;
				end
			end
			ST_DRAIN_RD: state_d = ST_DRAIN_PUSH;
			ST_DRAIN_PUSH: begin
				if (out_free)
					state_d = drain_last ? ST_IDLE : ST_DRAIN_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		op.go     = 1'b0;
		op.sub    = fwd ? !step_q : step_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q[IDX_W-1:0];
		ram_wdata = sample;
		ram_re    = 1'b0;
		ram_raddr = low_idx[IDX_W-1:0];
		load_out  = 1'b0;
		load_data = res_q;
		load_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !fwd) begin
					ram_we = inv_first;
					ram_re = !inv_first;
				end
			end
			ST_ISSUE: op.go = 1'b1;
			ST_WAIT: begin
				// forward difference goes to the store
				if (unit_done && fwd && !step_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[POS_W-1:1];
					ram_wdata = unit_result;
				end
			end
			ST_PUSH: begin
				load_out  = out_free;
				load_last = !fwd && step_q && is_last;
			end
			ST_DRAIN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = didx_q;
			end
			ST_DRAIN_PUSH: begin
				load_out  = out_free;
				load_data = ram_rdata;
				load_last = drain_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			line_length_q <= LEN_W'(MAX_LINE);
			direction_q   <= DIR_FORWARD;
			pos_q         <= '0;
			step_q        <= 1'b0;
			didx_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_write && cfg_index == CFG_LINE_LENGTH)
				line_length_q <= cfg_data;
			if (cfg_write && cfg_index == CFG_DIRECTION)
				direction_q <= cfg_data[0];

			// restart the line on a write to the length or direction register
			if (cfg_hit)
				pos_q <= '0;
			else if (state_q == ST_IDLE && accept && (fwd ? !pos_q[0] : inv_first))
				pos_q <= pos_q + POS_W'(1);
			else if (state_q == ST_PUSH && out_free && step_q)
				pos_q <= is_last ? '0 : pos_q + POS_W'(1);

			if (state_q == ST_WAIT && unit_done && fwd && !step_q)
				step_q <= 1'b1;
			else if (state_q == ST_PUSH && out_free)
				step_q <= !step_q;

			if (state_q == ST_PUSH)
				didx_q <= '0;
			else if (state_q == ST_DRAIN_PUSH && out_free)
				didx_q <= didx_q + IDX_W'(1);

			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			s_q <= sample;
		if (state_q == ST_IDLE && accept && fwd && !pos_q[0])
			held_q <= sample;
		else if (state_q == ST_RDLOW)
			held_q <= ram_rdata;
		if (state_q == ST_WAIT && unit_done)
			res_q <= unit_result;
		if (load_out) begin
			coef_q <= load_data;
			last_q <= load_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign coefficient  = coef_q;
	assign last_of_line = last_q;

endmodule

`default_nettype wire

// File: rtl/core/hlt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hlt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/hlt_scale.sv
// Shared five-stage unit: (a +/- b) * 1/sqrt2, rounded half away from zero,
// saturated to 32 bits. Depends on hlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlt_scale
	import hlt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hlt_op_t           op,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output logic      [DATA_W-1:0] result,
	output logic                   done
);

	localparam int SUM_W  = DATA_W + 1;
	localparam int PROD_W = SUM_W + COEF_W;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_W - 1);
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic [SUM_W-1:0]  sum_s1;
	logic [SUM_W-1:0]  mag_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [PROD_W-1:0] rounded;
	logic [SUM_W-1:0]  q_s4;
	logic [DATA_W-1:0] result_s5;
	logic              neg_s2, neg_s3, neg_s4;
	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	assign rounded = prod_s3 + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= op.go;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// full-width sum or difference
		if (op.sub)
			sum_s1 <= {a[DATA_W-1], a} - {b[DATA_W-1], b};
		else
			sum_s1 <= {a[DATA_W-1], a} + {b[DATA_W-1], b};

		neg_s2 <= sum_s1[SUM_W-1];
		mag_s2 <= sum_s1[SUM_W-1] ? (~sum_s1 + SUM_W'(1)) : sum_s1;

		neg_s3  <= neg_s2;
		prod_s3 <= PROD_W'(mag_s2) * PROD_W'(INV_SQRT2_Q16);

		neg_s4 <= neg_s3;
		q_s4   <= rounded[PROD_W-1:COEF_W];

		// saturate and restore sign
		if (neg_s4) begin
			if (q_s4 > {1'b0, SAT_MIN})
				result_s5 <= SAT_MIN;
			else
				result_s5 <= ~q_s4[DATA_W-1:0] + DATA_W'(1);
		end else begin
			if (q_s4[SUM_W-1:DATA_W-1] != 2'b00)
				result_s5 <= SAT_MAX;
			else
				result_s5 <= q_s4[DATA_W-1:0];
		end
	end

	assign result = result_s5;
	assign done   = valid_s5;

endmodule

`default_nettype wire

// File: rtl/core/hlt_checker.sv
// Port-level checks for haar_line_transform, attached by bind.
// Depends on hlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlt_checker
	import hlt_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DATA_W-1:0] coefficient,
	input wire logic              last_of_line
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coefficient) && $stable(last_of_line))
		else $error("stalled output beat changed");

	// results are produced only while an item is being worked on
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output beat appeared while idle");

	// the block goes busy only on an accepted input beat
	a_busy_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted beat");

endmodule

bind haar_line_transform hlt_checker u_hlt_checker (.*);

`default_nettype wire
